>>> rtl/core/psacia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psacia_pkg: shared types and constants
// transaction types, opcodes, register selects, status bits and byte times
// ----------------------------------------------------------------------------
package psacia_pkg;

	localparam int unsigned CLOCK_HZ = 895000;
	localparam int unsigned BIT_TIMES_PER_BYTE = 10;
	localparam int unsigned TIME_W = 20;
	localparam logic [TIME_W-1:0] TIME_MAX = 20'hFFFFF;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	localparam logic [1:0] SEL_DATA    = 2'd0;
	localparam logic [1:0] SEL_STATUS  = 2'd1;
	localparam logic [1:0] SEL_COMMAND = 2'd2;
	localparam logic [1:0] SEL_CONTROL = 2'd3;

	localparam int unsigned STAT_IRQ     = 7;
	localparam int unsigned STAT_TXEMPTY = 4;
	localparam int unsigned STAT_RXFULL  = 3;
	localparam int unsigned STAT_OVERRUN = 2;

	localparam int unsigned CMD_ECHO     = 4;
	localparam int unsigned CMD_RXIRQ_N  = 1;
	localparam logic [1:0]  CMD_TXIRQ_EN = 2'b01;
	localparam logic [7:0]  CMD_KEEP_MASK = 8'hE0;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [1:0]  reg_select;
		logic [7:0]  write_value;
		logic [11:0] tick_cycles;
		logic        rx_available;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_taken;
		logic       irq;
	} result_t;

	function automatic logic [TIME_W-1:0] sat_time(input longint unsigned t);
		logic [TIME_W-1:0] r;
		if (t > longint'(TIME_MAX)) begin
			r = TIME_MAX;
		end else if (t < 1) begin
			r = 20'd1;
		end else begin
			r = t[TIME_W-1:0];
		end
		return r;
	endfunction

	localparam longint unsigned BYTE_CLKS = longint'(CLOCK_HZ) * BIT_TIMES_PER_BYTE;

	localparam logic [TIME_W-1:0] BYTE_TIME [16] = '{
		20'd1,
		sat_time(BYTE_CLKS / 50),   sat_time(BYTE_CLKS / 75),
		sat_time(BYTE_CLKS / 110),  sat_time(BYTE_CLKS / 134),
		sat_time(BYTE_CLKS / 150),  sat_time(BYTE_CLKS / 300),
		sat_time(BYTE_CLKS / 600),  sat_time(BYTE_CLKS / 1200),
		sat_time(BYTE_CLKS / 1800), sat_time(BYTE_CLKS / 2400),
		sat_time(BYTE_CLKS / 3600), sat_time(BYTE_CLKS / 4800),
		sat_time(BYTE_CLKS / 7200), sat_time(BYTE_CLKS / 9600),
		sat_time(BYTE_CLKS / 19200)
	};

endpackage
`default_nettype wire

>>> rtl/core/psacia_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psacia_in_reg: input register
// holds one incoming transaction until the core consumes it
// ----------------------------------------------------------------------------
module psacia_in_reg
	import psacia_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	input  wire logic  advance,
	output logic       valid_s1,
	output item_t      item_s1
);

	assign item_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/psacia_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psacia_core: register file and pacing state
// bus register access, transmit/receive pacers, echo, overrun and interrupt
// ----------------------------------------------------------------------------
module psacia_core
	import psacia_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  fire,
	input  wire item_t item_s1,
	output result_t    res
);

	logic [7:0]        command_q, control_q, rx_data_q, held_byte_q;
	logic              tx_empty_q, rx_full_q, overrun_q, irq_q, tx_active_q, held_valid_q;
	logic [TIME_W-1:0] tx_rem_q, rx_rem_q;

	logic [7:0]        command_n, control_n, rx_data_n, held_byte_n;
	logic              tx_empty_n, rx_full_n, overrun_n, irq_n, tx_active_n, held_valid_n;
	logic [TIME_W-1:0] tx_rem_n, rx_rem_n;

	logic [TIME_W-1:0] cyc, bt, tx_dn, rx_dn;
	logic [7:0]        rd, txb;
	logic              txv, taken;

	assign cyc   = {{(TIME_W-12){1'b0}}, item_s1.tick_cycles};
	assign bt    = BYTE_TIME[control_q[3:0]];
	assign tx_dn = (tx_rem_q > cyc) ? tx_rem_q - cyc : '0;
	assign rx_dn = (rx_rem_q > cyc) ? rx_rem_q - cyc : '0;

	always_comb begin
		command_n    = command_q;
		control_n    = control_q;
		rx_data_n    = rx_data_q;
		held_byte_n  = held_byte_q;
		tx_empty_n   = tx_empty_q;
		rx_full_n    = rx_full_q;
		overrun_n    = overrun_q;
		irq_n        = irq_q;
		tx_active_n  = tx_active_q;
		held_valid_n = held_valid_q;
		tx_rem_n     = tx_rem_q;
		rx_rem_n     = rx_rem_q;
		rd           = '0;
		txv          = 1'b0;
		txb          = '0;
		taken        = 1'b0;
		unique case (item_s1.opcode)
			OP_READ: begin
				unique case (item_s1.reg_select)
					SEL_DATA: begin
						rx_full_n = 1'b0;
						overrun_n = 1'b0;
						rd        = rx_data_q;
					end
					SEL_STATUS: begin
						rd[STAT_IRQ]     = irq_q;
						rd[STAT_TXEMPTY] = tx_empty_q;
						rd[STAT_RXFULL]  = rx_full_q;
						rd[STAT_OVERRUN] = overrun_q;
						irq_n            = 1'b0;
					end
					SEL_COMMAND: rd = command_q;
					SEL_CONTROL: rd = control_q;
				endcase
			end
			OP_WRITE: begin
				unique case (item_s1.reg_select)
					SEL_DATA: begin
						if (!tx_active_q) begin
							tx_active_n = 1'b1;
							tx_rem_n    = bt;
							tx_empty_n  = 1'b0;
							txv         = 1'b1;
							txb         = item_s1.write_value;
						end else begin
							held_valid_n = 1'b1;
							held_byte_n  = item_s1.write_value;
						end
					end
					SEL_STATUS: begin
						overrun_n  = 1'b0;
						rx_full_n  = 1'b0;
						tx_empty_n = 1'b1;
						irq_n      = 1'b0;
						command_n  = command_q & CMD_KEEP_MASK;
					end
					SEL_COMMAND: command_n = item_s1.write_value;
					SEL_CONTROL: control_n = item_s1.write_value;
				endcase
			end
			OP_TICK: begin
				if (tx_active_q) begin
					tx_rem_n = tx_dn;
					if (tx_dn == '0) begin
						tx_active_n = 1'b0;
						tx_empty_n  = 1'b1;
						if (command_q[3:2] == CMD_TXIRQ_EN) begin
							irq_n = 1'b1;
						end
						if (held_valid_q) begin
							held_valid_n = 1'b0;
							tx_active_n  = 1'b1;
							tx_rem_n     = bt;
							tx_empty_n   = 1'b0;
							txv          = 1'b1;
							txb          = held_byte_q;
						end
					end
				end
				rx_rem_n = rx_dn;
				if (rx_dn == '0 && item_s1.rx_available) begin
					taken    = 1'b1;
					rx_rem_n = bt;
					if (!rx_full_q) begin
						rx_data_n = item_s1.rx_byte;
						rx_full_n = 1'b1;
						if (!command_q[CMD_RXIRQ_N]) begin
							irq_n = 1'b1;
						end
						if (command_q[CMD_ECHO]) begin
							if (!tx_active_n) begin
								tx_active_n = 1'b1;
								tx_rem_n    = bt;
								tx_empty_n  = 1'b0;
								txv         = 1'b1;
								txb         = item_s1.rx_byte;
							end else begin
								held_valid_n = 1'b1;
								held_byte_n  = item_s1.rx_byte;
							end
						end
					end else begin
						overrun_n = 1'b1;
					end
				end
			end
			OP_NOP: ;
		endcase
	end

	always_comb begin
		res.read_data = rd;
		res.tx_valid  = txv;
		res.tx_byte   = txb;
		res.rx_taken  = taken;
		res.irq       = irq_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_q    <= '0;
			control_q    <= '0;
			rx_data_q    <= '0;
			held_byte_q  <= '0;
			tx_empty_q   <= 1'b1;
			rx_full_q    <= 1'b0;
			overrun_q    <= 1'b0;
			irq_q        <= 1'b0;
			tx_active_q  <= 1'b0;
			held_valid_q <= 1'b0;
			tx_rem_q     <= 20'd1;
			rx_rem_q     <= 20'd1;
		end else if (fire) begin
			command_q    <= command_n;
			control_q    <= control_n;
			rx_data_q    <= rx_data_n;
			held_byte_q  <= held_byte_n;
			tx_empty_q   <= tx_empty_n;
			rx_full_q    <= rx_full_n;
			overrun_q    <= overrun_n;
			irq_q        <= irq_n;
			tx_active_q  <= tx_active_n;
			held_valid_q <= held_valid_n;
			tx_rem_q     <= tx_rem_n;
			rx_rem_q     <= rx_rem_n;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/psacia_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psacia_out_reg: result register
// holds one finished result until the receiving side takes it
// ----------------------------------------------------------------------------
module psacia_out_reg
	import psacia_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    load,
	input  wire result_t res,
	output logic         free,
	output logic         result_valid,
	input  wire logic    result_stall,
	output result_t      result
);

	assign free = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result <= res;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/paced_serial_acia.sv
`default_nettype none
// ----------------------------------------------------------------------------
// paced_serial_acia: serial ACIA with paced transmit and receive
// bus reads, bus writes and time ticks in, one result per transaction out
// ----------------------------------------------------------------------------
// One transaction is accepted per clock while not stalled, giving exactly one
// result. It sits in the input register, then passes through the register and
// pacer update logic into the result register. Throughput is one transaction
// per clock while result_stall is low; the register state written by one
// transaction is seen by the very next one, so ticks and bus accesses may be
// issued back to back. Byte times come from a constant table indexed by
// control bits 3..0 and are held in 20-bit pacing counters.
module paced_serial_acia
	import psacia_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result
);

	logic    valid_s1, free, fire;
	item_t   item_s1;
	result_t res;

	assign fire = valid_s1 && free;

	psacia_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.advance    (free),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	psacia_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.item_s1 (item_s1),
		.res     (res)
	);

	psacia_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire),
		.res          (res),
		.free         (free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

>>> rtl/core/psacia_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psacia_checker: port-level checks
// result handshake, input stall and consistency of result fields
// ----------------------------------------------------------------------------
module psacia_checker
	import psacia_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_stall,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed");

	a_tx_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.tx_valid |-> result.tx_byte == 8'd0)
		else $error("tx byte without tx valid");

	a_read_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.read_data != 8'd0 |-> !result.tx_valid && !result.rx_taken)
		else $error("read data together with line activity");

	a_stall_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> $past(item_valid) || $past(item_stall))
		else $error("input stalled with no transaction held");

endmodule

bind paced_serial_acia psacia_checker u_checker (.*);
`default_nettype wire

>>> bench/tb_paced_serial_acia.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_paced_serial_acia: self-checking bench for the paced serial ACIA
// a directed table of bus accesses and ticks, then weighted random traffic,
// with random idle bursts on both channels; every result is compared field
// by field with the in-bench ACIA predictor or a typed row's fixed result,
// in order of acceptance
module tb_paced_serial_acia;
	import psacia_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 400;
	localparam int CALM_ITEMS = 60;

	typedef struct packed {
		item_t   stim;
		logic    typed;
		result_t want;
	} plan_t;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item_drv;
	logic    result_valid;
	logic    result_stall;
	result_t result_mon;

	bit      idle_on;
	int      errors;
	int      quiet;
	int      stall_left;
	plan_t   plan[$];
	result_t due_results[$];

	// predictor state
	logic [7:0]  acia_command, acia_control, acia_rxdata, acia_held;
	logic        acia_txempty, acia_rxfull, acia_overrun, acia_irq;
	logic        acia_txbusy, acia_heldv;
	logic [19:0] acia_txleft, acia_rxleft;
	logic        line_out_valid;
	logic [7:0]  line_out_byte;

	paced_serial_acia i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item_drv),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result_mon)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic [19:0] byte_clocks(input logic [3:0] sel);
		longint unsigned baud;
		longint unsigned t;
		case (sel)
			4'd1:    baud = 50;
			4'd2:    baud = 75;
			4'd3:    baud = 110;
			4'd4:    baud = 134;
			4'd5:    baud = 150;
			4'd6:    baud = 300;
			4'd7:    baud = 600;
			4'd8:    baud = 1200;
			4'd9:    baud = 1800;
			4'd10:   baud = 2400;
			4'd11:   baud = 3600;
			4'd12:   baud = 4800;
			4'd13:   baud = 7200;
			4'd14:   baud = 9600;
			4'd15:   baud = 19200;
			default: baud = 0;
		endcase
		if (baud == 0) begin
			t = 1;
		end else begin
			t = longint'(CLOCK_HZ) * 10 / baud;
		end
		if (t < 1) begin
			t = 1;
		end
		if (t > 64'hFFFFF) begin
			t = 64'hFFFFF;
		end
		return t[19:0];
	endfunction

	function automatic logic [19:0] count_down(input logic [19:0] v, input logic [11:0] c);
		return (v > {8'd0, c}) ? v - {8'd0, c} : 20'd0;
	endfunction

	task automatic acia_reset_state();
		acia_command = '0;
		acia_control = '0;
		acia_rxdata = '0;
		acia_held = '0;
		acia_txempty = 1'b1;
		acia_rxfull = 1'b0;
		acia_overrun = 1'b0;
		acia_irq = 1'b0;
		acia_txbusy = 1'b0;
		acia_heldv = 1'b0;
		acia_txleft = 20'd1;
		acia_rxleft = 20'd1;
	endtask

	task automatic line_send(input logic [7:0] b);
		if (!acia_txbusy) begin
			acia_txbusy = 1'b1;
			acia_txleft = byte_clocks(acia_control[3:0]);
			acia_txempty = 1'b0;
			line_out_valid = 1'b1;
			line_out_byte = b;
		end else begin
			acia_heldv = 1'b1;
			acia_held = b;
		end
	endtask

	task automatic compute_acia_result(input item_t it, output result_t r);
		logic [7:0] rd;
		logic       taken;
		rd = '0;
		taken = 1'b0;
		line_out_valid = 1'b0;
		line_out_byte = '0;
		case (it.opcode)
			OP_READ: begin
				case (it.reg_select)
					SEL_DATA: begin
						acia_rxfull = 1'b0;
						acia_overrun = 1'b0;
						rd = acia_rxdata;
					end
					SEL_STATUS: begin
						rd[STAT_IRQ] = acia_irq;
						rd[STAT_TXEMPTY] = acia_txempty;
						rd[STAT_RXFULL] = acia_rxfull;
						rd[STAT_OVERRUN] = acia_overrun;
						acia_irq = 1'b0;
					end
					SEL_COMMAND: rd = acia_command;
					default: rd = acia_control;
				endcase
			end
			OP_WRITE: begin
				case (it.reg_select)
					SEL_DATA: line_send(it.write_value);
					SEL_STATUS: begin
						acia_overrun = 1'b0;
						acia_rxfull = 1'b0;
						acia_txempty = 1'b1;
						acia_irq = 1'b0;
						acia_command = acia_command & CMD_KEEP_MASK;
					end
					SEL_COMMAND: acia_command = it.write_value;
					default: acia_control = it.write_value;
				endcase
			end
			OP_TICK: begin
				if (acia_txbusy) begin
					acia_txleft = count_down(acia_txleft, it.tick_cycles);
					if (acia_txleft == 20'd0) begin
						acia_txbusy = 1'b0;
						acia_txempty = 1'b1;
						if (acia_command[3:2] == CMD_TXIRQ_EN) begin
							acia_irq = 1'b1;
						end
						if (acia_heldv) begin
							acia_heldv = 1'b0;
							line_send(acia_held);
						end
					end
				end
				acia_rxleft = count_down(acia_rxleft, it.tick_cycles);
				if (acia_rxleft == 20'd0 && it.rx_available) begin
					taken = 1'b1;
					if (!acia_rxfull) begin
						acia_rxdata = it.rx_byte;
						acia_rxfull = 1'b1;
						if (!acia_command[CMD_RXIRQ_N]) begin
							acia_irq = 1'b1;
						end
						acia_rxleft = byte_clocks(acia_control[3:0]);
						if (acia_command[CMD_ECHO]) begin
							line_send(it.rx_byte);
						end
					end else begin
						acia_overrun = 1'b1;
						acia_rxleft = byte_clocks(acia_control[3:0]);
					end
				end
			end
			default: begin
			end
		endcase
		r.read_data = rd;
		r.tx_valid = line_out_valid;
		r.tx_byte = line_out_byte;
		r.rx_taken = taken;
		r.irq = acia_irq;
	endtask

	task automatic plan_row(input logic [1:0] op, input logic [1:0] rs, input logic [7:0] wv,
			input logic [11:0] cyc, input logic av, input logic [7:0] rb);
		plan_t p;
		p = '0;
		p.stim.opcode = op;
		p.stim.reg_select = rs;
		p.stim.write_value = wv;
		p.stim.tick_cycles = cyc;
		p.stim.rx_available = av;
		p.stim.rx_byte = rb;
		plan.push_back(p);
	endtask

	// bus access rows whose result is plain: no rx take, irq low
	task automatic plan_typed(input logic [1:0] op, input logic [1:0] rs, input logic [7:0] wv,
			input logic [7:0] rd, input logic tv, input logic [7:0] tb);
		plan_t p;
		p = '0;
		p.stim.opcode = op;
		p.stim.reg_select = rs;
		p.stim.write_value = wv;
		p.typed = 1'b1;
		p.want.read_data = rd;
		p.want.tx_valid = tv;
		p.want.tx_byte = tb;
		plan.push_back(p);
	endtask

	function automatic item_t random_item();
		item_t   it;
		int unsigned k;
		int unsigned w;
		it.opcode = OP_TICK;
		it.reg_select = 2'($urandom_range(0, 3));
		it.write_value = 8'($urandom_range(0, 255));
		it.tick_cycles = 12'($urandom_range(0, 4095));
		it.rx_available = 1'($urandom_range(0, 1));
		it.rx_byte = 8'($urandom_range(0, 255));
		k = $urandom_range(0, 99);
		if (k < 45) begin
			w = $urandom_range(0, 3);
			if (w == 1) begin
				it.tick_cycles = 12'($urandom_range(0, 15));
			end else if (w > 1) begin
				it.tick_cycles = 12'($urandom_range(0, 600));
			end
			it.rx_available = ($urandom_range(0, 9) < 7);
		end else if (k < 65) begin
			it.opcode = OP_READ;
		end else if (k < 95) begin
			it.opcode = OP_WRITE;
			w = $urandom_range(0, 99);
			if (w < 50) begin
				it.reg_select = SEL_DATA;
			end else if (w < 65) begin
				it.reg_select = SEL_CONTROL;
				w = $urandom_range(0, 99);
				if (w < 40) begin
					it.write_value[3:0] = 4'hF;
				end else if (w < 60) begin
					it.write_value[3:0] = 4'hE;
				end else if (w < 75) begin
					it.write_value[3:0] = 4'h0;
				end else if (w < 85) begin
					it.write_value[3:0] = 4'($urandom_range(12, 13));
				end else if (w < 95) begin
					it.write_value[3:0] = 4'($urandom_range(8, 11));
				end
			end else if (w < 85) begin
				it.reg_select = SEL_COMMAND;
				if ($urandom_range(0, 9) < 7) begin
					it.write_value[3:2] = CMD_TXIRQ_EN;
				end
			end else begin
				it.reg_select = SEL_STATUS;
			end
		end else if (k < 98) begin
			it.opcode = OP_NOP;
		end else begin
			it.tick_cycles = '0;
			it.rx_available = 1'b0;
		end
		return it;
	endfunction

	task automatic offer_item(input item_t it, input logic typed, input result_t want);
		int      gap;
		result_t r;
		@(negedge clk);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 6);
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item_drv <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		compute_acia_result(it, r);
		due_results.push_back(typed ? want : r);
	endtask

	// result side back-pressure in bursts
	initial begin
		result_stall = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_stall <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 5);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : result_check
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (due_results.size() == 0) begin
				$error("unexpected result transaction %h", result_mon);
				errors++;
			end else begin
				want = due_results.pop_front();
				if (result_mon.read_data !== want.read_data) begin
					$error("read_data expected %h got %h", want.read_data, result_mon.read_data);
					errors++;
				end
				if (result_mon.tx_valid !== want.tx_valid) begin
					$error("tx_valid expected %b got %b", want.tx_valid, result_mon.tx_valid);
					errors++;
				end
				if (result_mon.tx_byte !== want.tx_byte) begin
					$error("tx_byte expected %h got %h", want.tx_byte, result_mon.tx_byte);
					errors++;
				end
				if (result_mon.rx_taken !== want.rx_taken) begin
					$error("rx_taken expected %b got %b", want.rx_taken, result_mon.rx_taken);
					errors++;
				end
				if (result_mon.irq !== want.irq) begin
					$error("irq expected %b got %b", want.irq, result_mon.irq);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("tb_paced_serial_acia: errors");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item_drv = '0;
		idle_on = 1'b1;
		errors = 0;
		quiet = 0;
		acia_reset_state();

		// reset values and register readback
		plan_typed(OP_READ, SEL_STATUS, 8'h00, 8'h10, 1'b0, 8'h00);
		plan_typed(OP_READ, SEL_COMMAND, 8'h00, 8'h00, 1'b0, 8'h00);
		plan_typed(OP_READ, SEL_DATA, 8'h00, 8'h00, 1'b0, 8'h00);
		plan_typed(OP_WRITE, SEL_CONTROL, 8'h0F, 8'h00, 1'b0, 8'h00);
		plan_typed(OP_WRITE, SEL_COMMAND, 8'h14, 8'h00, 1'b0, 8'h00);
		plan_typed(OP_READ, SEL_COMMAND, 8'h00, 8'h14, 1'b0, 8'h00);
		plan_typed(OP_READ, SEL_CONTROL, 8'h00, 8'h0F, 1'b0, 8'h00);
		// send, then hold, then replace the held byte
		plan_typed(OP_WRITE, SEL_DATA, 8'h00, 8'h00, 1'b1, 8'h00);
		plan_typed(OP_WRITE, SEL_DATA, 8'hFF, 8'h00, 1'b0, 8'h00);
		plan_typed(OP_WRITE, SEL_DATA, 8'hA5, 8'h00, 1'b0, 8'h00);
		// pacing, receive with echo, overrun
		plan_row(OP_TICK, SEL_DATA, 8'h00, 12'd0, 1'b1, 8'h3C);
		plan_row(OP_TICK, SEL_CONTROL, 8'hFF, 12'hFFF, 1'b1, 8'hFF);
		plan_row(OP_TICK, SEL_DATA, 8'h00, 12'hFFF, 1'b1, 8'h3C);
		plan_row(OP_READ, SEL_STATUS, 8'hFF, 12'hFFF, 1'b1, 8'hFF);
		plan_row(OP_READ, SEL_STATUS, 8'h00, 12'd0, 1'b0, 8'h00);
		plan_row(OP_READ, SEL_DATA, 8'h00, 12'd0, 1'b1, 8'h00);
		plan_row(OP_TICK, SEL_DATA, 8'h00, 12'd1, 1'b0, 8'h00);
		plan_row(OP_WRITE, SEL_STATUS, 8'hFF, 12'd0, 1'b0, 8'h00);
		plan_row(OP_NOP, SEL_CONTROL, 8'hFF, 12'hFFF, 1'b1, 8'hFF);
		// unpaced baud, receive interrupt off
		plan_row(OP_WRITE, SEL_CONTROL, 8'h00, 12'd0, 1'b0, 8'h00);
		plan_row(OP_WRITE, SEL_COMMAND, 8'h02, 12'd0, 1'b0, 8'h00);
		plan_row(OP_TICK, SEL_DATA, 8'h00, 12'hFFF, 1'b1, 8'h81);
		plan_row(OP_TICK, SEL_DATA, 8'h00, 12'd0, 1'b1, 8'h7E);
		plan_row(OP_TICK, SEL_DATA, 8'h00, 12'd1, 1'b1, 8'h7E);
		plan_row(OP_TICK, SEL_DATA, 8'h00, 12'd1, 1'b0, 8'h00);
		// programmed reset keeps command bits 7..5; a tick at the slowest baud
		plan_row(OP_WRITE, SEL_COMMAND, 8'hFF, 12'd0, 1'b0, 8'h00);
		plan_row(OP_WRITE, SEL_STATUS, 8'h00, 12'd0, 1'b0, 8'h00);
		plan_row(OP_READ, SEL_COMMAND, 8'h00, 12'd0, 1'b0, 8'h00);
		plan_row(OP_WRITE, SEL_CONTROL, 8'h01, 12'd0, 1'b0, 8'h00);
		plan_row(OP_TICK, SEL_DATA, 8'h00, 12'hFFF, 1'b0, 8'h00);
		plan_row(OP_WRITE, SEL_CONTROL, 8'hFF, 12'd0, 1'b0, 8'h00);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			offer_item(plan[i].stim, plan[i].typed, plan[i].want);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
				idle_on = 1'b0;
			end else if (n % 40 == 0) begin
				idle_on = ($urandom_range(0, 2) != 0);
			end
			offer_item(random_item(), 1'b0, '0);
		end

		@(negedge clk);
		item_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("tb_paced_serial_acia: clean");
		end else begin
			$display("tb_paced_serial_acia: errors");
		end
		$finish;
	end

endmodule
